[design/mmnb_pkg.sv]
package mmnb_pkg;

  localparam int BYTE_W = 8;
  localparam int DIV_STEPS = BYTE_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[design/mmnb_if.sv]
interface mmnb_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           first;

  modport source (output valid, output operation, output sample, output first, input ready);
  modport sink   (input valid, input operation, input sample, input first, output ready);
endinterface

interface mmnb_out_if;
  import mmnb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              span_zero;
  logic              clipped;

  modport source (output valid, output byte_value, output span_zero, output clipped,
                  input ready);
  modport sink   (input valid, input byte_value, input span_zero, input clipped,
                  output ready);
endinterface

[design/mmnb_div.sv]
module mmnb_div
  import mmnb_pkg::*;
#(
  parameter int DEN_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DEN_W+BYTE_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic [BYTE_W-1:0]       quot
);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DEN_W:0] sh;
  logic [DEN_W:0] sub;
  logic           ge;

  always_comb begin
    sh  = {rem_r, quo_r[BYTE_W-1]};
    sub = sh - {1'b0, den};
    ge  = (sh >= {1'b0, den});

    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      rem_nxt  = num[DEN_W+BYTE_W-1:BYTE_W];
      quo_nxt  = num[BYTE_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? sub[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_nxt = {quo_r[BYTE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

[design/min_max_normalize_to_byte.sv]
// A measure beat updates the running minimum and maximum in its accept cycle and gives no result.
// A convert beat in range goes through PREP, LOAD and DIV, where it waits on the 8-step serial
// divider, then DONE; zero-span and out-of-range beats go from PREP straight to DONE.
// A new beat is accepted in the cycle after the previous result enters the output register.
// Reset is synchronous and active low; it clears the minimum, maximum and measured flag to zero.
module min_max_normalize_to_byte
  import mmnb_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  mmnb_in_if.sink         in_ch,
  mmnb_out_if.source      out_ch
);

  localparam int SW = SAMPLE_WIDTH;

  state_t state_r, state_nxt;

  logic signed [SW-1:0] min_r, min_nxt;
  logic signed [SW-1:0] max_r, max_nxt;
  logic                 measured_r, measured_nxt;
  logic signed [SW-1:0] x_r, x_nxt;
  logic [SW-1:0]        span_r, span_nxt;
  logic [SW-1:0]        diff_r, diff_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic                 sz_r, sz_nxt;
  logic                 clip_r, clip_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_sz_r, out_sz_nxt;
  logic              out_clip_r, out_clip_nxt;

  logic [SW:0]          span_w;
  logic [SW:0]          diff_w;
  logic [SW+BYTE_W-1:0] num_w;
  logic                 div_start;
  logic                 div_done;
  logic [BYTE_W-1:0]    div_quot;
  logic signed [SW-1:0] smp;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign smp = in_ch.sample;

  assign span_w = {max_r[SW-1], max_r} - {min_r[SW-1], min_r};
  assign diff_w = {x_r[SW-1], x_r} - {min_r[SW-1], min_r};
  assign num_w  = {diff_r, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, diff_r};
  assign div_start = (state_r == ST_LOAD);

  mmnb_div #(
    .DEN_W (SW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_w),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    measured_nxt  = measured_r;
    x_nxt         = x_r;
    span_nxt      = span_r;
    diff_nxt      = diff_r;
    byte_nxt      = byte_r;
    sz_nxt        = sz_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_sz_nxt    = out_sz_r;
    out_clip_nxt  = out_clip_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_MEASURE) begin
            if (in_ch.first || !measured_r) begin
              min_nxt      = smp;
              max_nxt      = smp;
              measured_nxt = 1'b1;
            end else begin
              if (smp < min_r) min_nxt = smp;
              if (smp > max_r) max_nxt = smp;
            end
          end else begin
            x_nxt     = smp;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        span_nxt = span_w[SW-1:0];
        diff_nxt = diff_w[SW-1:0];
        byte_nxt = '0;
        sz_nxt   = 1'b0;
        clip_nxt = 1'b0;
        if (span_w == '0) begin
          sz_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else if (x_r < min_r) begin
          clip_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (x_r > max_r) begin
          byte_nxt  = BYTE_MAX;
          clip_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          byte_nxt  = div_quot;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r;
          out_sz_nxt    = sz_r;
          out_clip_nxt  = clip_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= '0;
      max_r       <= '0;
      measured_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      measured_r  <= measured_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    span_r     <= span_nxt;
    diff_r     <= diff_nxt;
    byte_r     <= byte_nxt;
    sz_r       <= sz_nxt;
    clip_r     <= clip_nxt;
    out_byte_r <= out_byte_nxt;
    out_sz_r   <= out_sz_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_value = out_byte_r;
  assign out_ch.span_zero  = out_sz_r;
  assign out_ch.clipped    = out_clip_r;

endmodule

[design/mmnb_checker.sv]
module mmnb_checker
  import mmnb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] byte_value,
  input logic              span_zero,
  input logic              clipped
);

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(span_zero && clipped))
    else $error("span_zero and clipped both set");

  a_zero_span_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && span_zero) |-> (byte_value == '0))
    else $error("zero span beat carries a nonzero byte");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && clipped) |-> (byte_value == '0 || byte_value == BYTE_MAX))
    else $error("clipped beat is not saturated");

  a_measure_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_MEASURE && !out_valid) |=> !out_valid)
    else $error("measure beat produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(byte_value)))
    else $error("stalled result changed");

endmodule

bind min_max_normalize_to_byte mmnb_checker u_mmnb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .byte_value   (out_ch.byte_value),
  .span_zero    (out_ch.span_zero),
  .clipped      (out_ch.clipped)
);
